// ===== sv/chunked_xor_interleave_cipher_top_defines.svh =====
// Assertion macros shared by the cipher RTL.
`ifndef CHUNKED_XOR_INTERLEAVE_CIPHER_TOP_DEFINES_SVH
`define CHUNKED_XOR_INTERLEAVE_CIPHER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Property must hold on every clock edge outside reset
`define CXIC_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("cxic assertion failed");
// Condition must never be seen outside reset
`define CXIC_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("cxic forbidden condition seen");
`else
`define CXIC_ASSERT(name, clk, rst_n, prop)
`define CXIC_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== sv/cxic_pkg.sv =====
package cxic_pkg;

	// Field and register widths
	localparam int OFFSET_BITS   = 24;
	localparam int LEN_BITS      = 24;
	localparam int CHUNK_BITS    = 16;
	localparam int KEY_BITS      = 8;
	localparam int BYTE_BITS     = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;
	localparam int REM_CNT_BITS  = $clog2(LEN_BITS + 1);
	localparam int OUT_DATA_BITS = ((BYTE_BITS + OFFSET_BITS + 7) / 8) * 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECTION    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_LENGTH = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_KEY    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_STEP     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CHUNK_SIZE   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PROCESS  = 3'd5;

	// Direction codes
	localparam logic DIR_DECRYPT = 1'b0;
	localparam logic DIR_ENCRYPT = 1'b1;

	// Dividend select for the shared remainder unit
	localparam logic DIV_SEL_TOTAL = 1'b0;
	localparam logic DIV_SEL_LIMIT = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_sel;
		logic store_r;
		logic store_m;
		logic region_calc;
		logic region_set;
		logic check;
		logic chunk;
		logic pos;
		logic map;
		logic mul;
		logic emit;
	} cxic_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic region_ready;
		logic rem_done;
		logic in_region;
		logic out_free;
	} cxic_status_t;

endpackage

// ===== sv/cxic_rem.sv =====
`include "chunked_xor_interleave_cipher_top_defines.svh"

module cxic_rem (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [cxic_pkg::LEN_BITS-1:0]   dividend,
	input  logic [cxic_pkg::CHUNK_BITS-1:0] divisor,
	output logic                            done,
	output logic [cxic_pkg::CHUNK_BITS-1:0] rem
);

	localparam int LB = cxic_pkg::LEN_BITS;
	localparam int CB = cxic_pkg::CHUNK_BITS;
	localparam int NB = cxic_pkg::REM_CNT_BITS;

	logic          busy_q;
	logic          done_q;
	logic [NB-1:0] cnt_q;
	logic [LB-1:0] dvd_q;
	logic [CB-1:0] dsr_q;
	logic [CB-1:0] rem_q;
	logic [CB:0]   trial;
	logic          fits;

	// One restoring step: bring down the next dividend bit
	assign trial = {rem_q, dvd_q[LB-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	// Iterate one bit per cycle, most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NB'(LB);
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= fits ? CB'(trial - {1'b0, dsr_q}) : trial[CB-1:0];
				dvd_q <= {dvd_q[LB-2:0], 1'b0};
				cnt_q <= cnt_q - NB'(1);
				if (cnt_q == NB'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	`CXIC_ASSERT_NEVER(a_start_while_busy, clk, arst_n, start && busy_q)
	`CXIC_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> !busy_q)
	`CXIC_ASSERT(a_rem_below_divisor, clk, arst_n, done_q |-> (rem_q < dsr_q))

endmodule

// ===== sv/cxic_ctrl.sv =====
`include "chunked_xor_interleave_cipher_top_defines.svh"

module cxic_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  cxic_pkg::cxic_status_t  status,
	output cxic_pkg::cxic_cmd_t     cmd
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DIV_TL  = 4'd1;
	localparam logic [3:0] ST_DIV_MPL = 4'd2;
	localparam logic [3:0] ST_REG1    = 4'd3;
	localparam logic [3:0] ST_REG2    = 4'd4;
	localparam logic [3:0] ST_CHECK   = 4'd5;
	localparam logic [3:0] ST_CHUNK   = 4'd6;
	localparam logic [3:0] ST_POS     = 4'd7;
	localparam logic [3:0] ST_MAP     = 4'd8;
	localparam logic [3:0] ST_MUL     = 4'd9;
	localparam logic [3:0] ST_EMIT    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Sequence one byte through region setup, chunk tracking and mapping
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (!status.region_ready) begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = cxic_pkg::DIV_SEL_TOTAL;
						state_d       = ST_DIV_TL;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_DIV_TL: begin
				if (status.rem_done) begin
					cmd.store_r   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = cxic_pkg::DIV_SEL_LIMIT;
					state_d       = ST_DIV_MPL;
				end
			end
			ST_DIV_MPL: begin
				if (status.rem_done) begin
					cmd.store_m = 1'b1;
					state_d     = ST_REG1;
				end
			end
			ST_REG1: begin
				cmd.region_calc = 1'b1;
				state_d         = ST_REG2;
			end
			ST_REG2: begin
				cmd.region_set = 1'b1;
				state_d        = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_CHUNK;
			end
			ST_CHUNK: begin
				if (status.in_region) begin
					cmd.chunk = 1'b1;
					state_d   = ST_POS;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_POS: begin
				cmd.pos = 1'b1;
				state_d = ST_MAP;
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CXIC_ASSERT(a_new_file_divides, clk, arst_n,
		(accept && !status.region_ready) |=> (state_q == ST_DIV_TL))
	`CXIC_ASSERT(a_emit_into_free_slot, clk, arst_n, cmd.emit |-> status.out_free)
	`CXIC_ASSERT(a_region_set_sticks, clk, arst_n, cmd.region_set |=> status.region_ready)

endmodule

// ===== sv/cxic_dp.sv =====
`include "chunked_xor_interleave_cipher_top_defines.svh"

module cxic_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cxic_pkg::cxic_cmd_t                    cmd,
	output cxic_pkg::cxic_status_t                 status,
	input  logic                                   cfg_valid,
	input  logic [cxic_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [cxic_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic [cxic_pkg::BYTE_BITS-1:0]         s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [cxic_pkg::OUT_DATA_BITS-1:0]     m_tdata,
	output logic                                   m_tlast
);

	localparam int OB = cxic_pkg::OFFSET_BITS;
	localparam int LB = cxic_pkg::LEN_BITS;
	localparam int CB = cxic_pkg::CHUNK_BITS;
	localparam int KB = cxic_pkg::KEY_BITS;
	localparam int BB = cxic_pkg::BYTE_BITS;
	localparam int DB = cxic_pkg::OUT_DATA_BITS;

	// Configuration registers
	logic          direction_q;
	logic [LB-1:0] total_length_q;
	logic [KB-1:0] start_key_q;
	logic [KB-1:0] key_step_q;
	logic [CB-1:0] chunk_size_q;
	logic [LB-1:0] max_process_q;

	// File and chunk state
	logic [OB-1:0] byte_count_q;
	logic          region_ready_q;
	logic [OB-1:0] region_end_q;
	logic [OB-1:0] base_q;
	logic [CB-1:0] len_q;

	// Per byte working registers
	logic [BB-1:0] byte_q;
	logic [CB-1:0] r_q;
	logic [CB-1:0] m_q;
	logic [LB-1:0] p_q;
	logic [LB:0]   lim_q;
	logic          in_region_q;
	logic          need_chunk_q;
	logic [CB-1:0] j_q;
	logic [CB-1:0] half_q;
	logic [CB-1:0] k_q;
	logic [CB-1:0] lo_q;
	logic [OB-1:0] off_q;
	logic [KB-1:0] prod_q;

	// Output register
	logic          m_tvalid_q;
	logic [BB-1:0] out_byte_q;
	logic [OB-1:0] out_off_q;
	logic          out_last_q;

	logic [CB-1:0]   eff_c;
	logic [LB-1:0]   div_dvd;
	logic            rem_done;
	logic [CB-1:0]   rem_val;
	logic [CB:0]     tail;
	logic [LB:0]     lim_d;
	logic [OB:0]     chunk_end;
	logic [OB-1:0]   rem_len;
	logic [CB-1:0]   d_val;
	logic [CB-1:0]   k_d;
	logic [CB-1:0]   lo_d;
	logic [KB-1:0]   kidx;
	logic [2*KB-1:0] prod_full;
	logic            last_d;
	logic            out_free;

	// Chunk size zero behaves as one
	assign eff_c   = (chunk_size_q == '0) ? CB'(1) : chunk_size_q;
	assign div_dvd = (cmd.div_sel == cxic_pkg::DIV_SEL_LIMIT) ? max_process_q : total_length_q;

	cxic_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (eff_c),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q    <= cxic_pkg::DIR_DECRYPT;
			total_length_q <= '0;
			start_key_q    <= '0;
			key_step_q     <= '0;
			chunk_size_q   <= CB'(64);
			max_process_q  <= LB'(10240);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cxic_pkg::CFG_DIRECTION:    direction_q    <= cfg_data[0];
				cxic_pkg::CFG_TOTAL_LENGTH: total_length_q <= cfg_data[LB-1:0];
				cxic_pkg::CFG_START_KEY:    start_key_q    <= cfg_data[KB-1:0];
				cxic_pkg::CFG_KEY_STEP:     key_step_q     <= cfg_data[KB-1:0];
				cxic_pkg::CFG_CHUNK_SIZE:   chunk_size_q   <= cfg_data[CB-1:0];
				cxic_pkg::CFG_MAX_PROCESS:  max_process_q  <= cfg_data[LB-1:0];
				default: ;
			endcase
		end
	end

	// Region: drop a short remainder and an odd byte, cap at whole chunks
	assign tail  = {1'b0, ((r_q < (eff_c >> 2)) ? r_q : '0)} + (CB+1)'(total_length_q[0]);
	assign lim_d = (m_q == '0) ? {1'b0, max_process_q}
	                           : {1'b0, max_process_q} + (LB+1)'(eff_c - m_q);

	// Chunk bounds and remaining region
	assign chunk_end = {1'b0, base_q} + (OB+1)'(len_q);
	assign rem_len   = region_end_q - byte_count_q;

	// Map chunk position to stored index and in-chunk offset
	assign d_val = len_q - CB'(1) - j_q;
	always_comb begin
		if (direction_q == cxic_pkg::DIR_DECRYPT) begin
			k_d = j_q;
			if (j_q < half_q) begin
				lo_d = len_q - CB'(1) - (j_q << 1);
			end else begin
				lo_d = len_q - CB'(2) - ((j_q - half_q) << 1);
			end
		end else begin
			k_d  = d_val[0] ? (half_q + (d_val >> 1)) : (d_val >> 1);
			lo_d = k_d;
		end
	end

	// Key index is only needed modulo 256
	assign kidx      = base_q[KB-1:0] + k_q[KB-1:0];
	assign prod_full = kidx * key_step_q;

	assign last_d   = (total_length_q != '0) &&
	                  (LB'(byte_count_q) == (total_length_q - LB'(1)));
	assign out_free = !m_tvalid_q || m_tready;

	// Per byte pipeline of the mapping steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q       <= '0;
			r_q          <= '0;
			m_q          <= '0;
			p_q          <= '0;
			lim_q        <= '0;
			in_region_q  <= 1'b0;
			need_chunk_q <= 1'b0;
			j_q          <= '0;
			half_q       <= '0;
			k_q          <= '0;
			lo_q         <= '0;
			off_q        <= '0;
			prod_q       <= '0;
		end else begin
			if (cmd.capture) begin
				byte_q <= s_tdata;
			end
			if (cmd.store_r) begin
				r_q <= rem_val;
			end
			if (cmd.store_m) begin
				m_q <= rem_val;
			end
			if (cmd.region_calc) begin
				p_q   <= (LB'(tail) > total_length_q) ? '0 : total_length_q - LB'(tail);
				lim_q <= lim_d;
			end
			if (cmd.check) begin
				in_region_q  <= (byte_count_q < region_end_q);
				need_chunk_q <= (byte_count_q < base_q) ||
				                ({1'b0, byte_count_q} >= chunk_end);
			end
			if (cmd.pos) begin
				j_q    <= CB'(byte_count_q - base_q);
				half_q <= CB'(({1'b0, len_q} + (CB+1)'(1)) >> 1);
			end
			if (cmd.map) begin
				k_q  <= k_d;
				lo_q <= lo_d;
			end
			if (cmd.mul) begin
				off_q  <= base_q + OB'(lo_q);
				prod_q <= prod_full[KB-1:0];
			end
		end
	end

	// File state: region, current chunk and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			region_ready_q <= 1'b0;
			region_end_q   <= '0;
			base_q         <= '0;
			len_q          <= '0;
		end else begin
			if (cmd.region_set) begin
				region_end_q   <= ({1'b0, p_q} < lim_q) ? OB'(p_q) : OB'(lim_q);
				region_ready_q <= 1'b1;
				base_q         <= '0;
				len_q          <= '0;
			end
			if (cmd.chunk && need_chunk_q) begin
				base_q <= byte_count_q;
				len_q  <= (OB'(eff_c) < rem_len) ? eff_c : CB'(rem_len);
			end
			if (cmd.emit) begin
				if (last_d) begin
					byte_count_q   <= '0;
					region_ready_q <= 1'b0;
				end else begin
					byte_count_q <= byte_count_q + OB'(1);
				end
			end
		end
	end

	// Hold a result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			out_byte_q <= '0;
			out_off_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
				out_byte_q <= in_region_q ? (byte_q ^ (start_key_q + prod_q)) : byte_q;
				out_off_q  <= in_region_q ? off_q : byte_count_q;
				out_last_q <= last_d;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DB'({out_off_q, out_byte_q});
	assign m_tlast  = out_last_q;

	assign status.region_ready = region_ready_q;
	assign status.rem_done     = rem_done;
	assign status.in_region    = in_region_q;
	assign status.out_free     = out_free;

	`CXIC_ASSERT(a_chunk_not_empty, clk, arst_n, cmd.pos |-> (len_q != '0))
	`CXIC_ASSERT(a_pos_inside_chunk, clk, arst_n, cmd.map |-> (j_q < len_q))
	`CXIC_ASSERT(a_offset_inside_chunk, clk, arst_n, cmd.mul |-> (lo_q < len_q))

endmodule

// ===== sv/chunked_xor_interleave_cipher_top.sv =====
// Chunked XOR interleave cipher. Each accepted byte gives exactly one result: the
// byte (XORed with a running key inside the processed region, unchanged outside it),
// the offset where it belongs in the output file, and a last flag on byte
// total_length-1. The first byte of a file is loaded into the output register only
// after the processed region is sized: two passes of the shared one-bit-per-cycle
// remainder unit, over all 24 dividend bits each, then the region setup steps. For
// every byte the controller's step sequence lies between acceptance and the load:
// chunk check, then position, mapping and key multiply inside the region only, then
// the output load. The block is ready for the next byte in the cycle after the load.
// The output load waits while the output register still holds an unaccepted result.
// One byte is in work at a time; the next byte is taken while the previous result
// still waits in the output register.
// Configuration writes are always taken (cfg_ready is tied high) and belong between
// files or while the block is idle.
module chunked_xor_interleave_cipher_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cxic_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [cxic_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [cxic_pkg::BYTE_BITS-1:0]      s_tdata,  // [7:0] data_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [cxic_pkg::OUT_DATA_BITS-1:0]  m_tdata,  // [7:0] out_byte, [31:8] out_offset
	output logic                                m_tlast   // last_byte
);

	cxic_pkg::cxic_cmd_t    cmd;
	cxic_pkg::cxic_status_t status;

	assign cfg_ready = 1'b1;

	cxic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cxic_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
